/* hw/rtl/cck_pkg.sv */
package cck_pkg;

  localparam logic [11:0] YearMax   = 12'd2999;
  localparam logic [11:0] YearReset = 12'd2000;
  localparam logic [6:0]  CentiLast = 7'd99;
  localparam logic [5:0]  SixtyLast = 6'd59;
  localparam logic [4:0]  HourLast  = 5'd23;
  localparam logic [3:0]  MonthLast = 4'd12;
  localparam int unsigned CenturyCount = 41;  // multiples of 100 that fit in 12 bits

  localparam logic [4:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_KNOB    = 2'd1,
    CMD_CONFIRM = 2'd2,
    CMD_START   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    FIELD_YEAR   = 3'd0,
    FIELD_MONTH  = 3'd1,
    FIELD_DAY    = 3'd2,
    FIELD_HOUR   = 3'd3,
    FIELD_MINUTE = 3'd4,
    FIELD_SECOND = 3'd5,
    FIELD_DONE   = 3'd6
  } field_e;

  // gregorian rule; century years found by comparing against each multiple of 100
  function automatic logic is_leap(input logic [11:0] y);
    logic century;
    logic quad_century;
    century      = 1'b0;
    quad_century = 1'b0;
    for (int i = 0; i < CenturyCount; i++) begin
      if (y == 12'(i * 100)) begin
        century      = 1'b1;
        quad_century = ((i % 4) == 0);
      end
    end
    return (y[1:0] == 2'b00) && (!century || quad_century);
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic [11:0] y);
    logic [3:0] mm;
    logic [4:0] len;
    mm = m;
    if (mm < 4'd1) mm = 4'd1;
    if (mm > MonthLast) mm = MonthLast;
    len = MonthLen[4'(mm - 4'd1)];
    if (mm == 4'd2 && is_leap(y)) len = 5'd29;
    return len;
  endfunction

endpackage

/* hw/rtl/calendar_clock_with_knob_setting.sv */
// Calendar clock with knob setting. Every accepted word (cmd_i, knob_i) yields exactly one
// result word carrying the full calendar state after that event: year, month, day, hour,
// minute, second, centiseconds, the running flag and the field being edited. After reset
// the clock reads 2000-01-01 00:00:00.00 and is in setting mode on the year field; knob
// samples set the current field, confirm presses step through year, month, day, hour,
// minute and second, and a start press after the last field makes ticks advance the time.
// A word is registered at the input and the calendar registers, which also serve as the
// result register, update when that word is processed, so one word is accepted per clock
// as long as the result is taken; a result left waiting on out_ready_i stalls the input.
// The carry and knob-scaling update of the calendar registers is combinational.
module calendar_clock_with_knob_setting import cck_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [9:0]  knob_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] year_out_o,
  output logic [3:0]  month_out_o,
  output logic [4:0]  day_out_o,
  output logic [4:0]  hour_out_o,
  output logic [5:0]  minute_out_o,
  output logic [5:0]  second_out_o,
  output logic [6:0]  centi_out_o,
  output logic        running_out_o,
  output logic [2:0]  edit_field_out_o
);

  // input register
  logic       in_valid_q, in_valid_d;
  cmd_e       cmd_q;
  logic [9:0] knob_q;

  // calendar state, doubles as the result register
  logic        out_valid_q, out_valid_d;
  logic [11:0] year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic [4:0]  day_q, day_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  minute_q, minute_d;
  logic [5:0]  second_q, second_d;
  logic [6:0]  centi_q, centi_d;
  logic        running_q, running_d;
  field_e      edit_q, edit_d;

  logic        fire;
  logic        editing;
  logic [4:0]  mdays;
  logic [11:0] span;
  logic        lo;
  logic [21:0] prod;
  logic [11:0] mapped;
  logic [11:0] hi;

  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;
  assign editing    = !running_q && (edit_q != FIELD_DONE);
  assign mdays      = month_days(month_q, year_q);

  always_comb begin
    in_valid_d  = in_ready_o ? in_valid_i : in_valid_q;
    out_valid_d = fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  // knob scaling: lo + knob * span / 1024, clamped to lo + span - 1
  always_comb begin
    span = 12'd0;
    lo   = 1'b0;
    case (edit_q)
      FIELD_YEAR:   span = 12'd3000;
      FIELD_MONTH:  begin span = 12'd12; lo = 1'b1; end
      FIELD_DAY:    begin span = 12'(mdays); lo = 1'b1; end
      FIELD_HOUR:   span = 12'd24;
      FIELD_MINUTE: span = 12'd60;
      FIELD_SECOND: span = 12'd60;
      default:      span = 12'd0;
    endcase
    prod   = 22'(knob_q) * 22'(span);
    hi     = 12'(lo) + span - 12'd1;
    mapped = 12'(lo) + prod[21:10];
    if (mapped > hi) mapped = hi;
  end

  always_comb begin
    year_d    = year_q;
    month_d   = month_q;
    day_d     = day_q;
    hour_d    = hour_q;
    minute_d  = minute_q;
    second_d  = second_q;
    centi_d   = centi_q;
    running_d = running_q;
    edit_d    = edit_q;
    if (fire) begin
      unique case (cmd_q)
        CMD_TICK: begin
          if (running_q) begin
            // carry cascade
            if (centi_q < CentiLast) begin
              centi_d = centi_q + 7'd1;
            end else begin
              centi_d = 7'd0;
              if (second_q < SixtyLast) begin
                second_d = second_q + 6'd1;
              end else begin
                second_d = 6'd0;
                if (minute_q < SixtyLast) begin
                  minute_d = minute_q + 6'd1;
                end else begin
                  minute_d = 6'd0;
                  if (hour_q < HourLast) begin
                    hour_d = hour_q + 5'd1;
                  end else begin
                    hour_d = 5'd0;
                    if ({1'b0, day_q} + 6'd1 <= {1'b0, mdays}) begin
                      day_d = day_q + 5'd1;
                    end else begin
                      day_d = 5'd1;
                      if (month_q < MonthLast) begin
                        month_d = month_q + 4'd1;
                      end else begin
                        month_d = 4'd1;
                        year_d  = (year_q >= YearMax) ? 12'd0 : year_q + 12'd1;
                      end
                    end
                  end
                end
              end
            end
          end
        end
        CMD_KNOB: begin
          if (editing) begin
            case (edit_q)
              FIELD_YEAR:   year_d   = mapped;
              FIELD_MONTH:  month_d  = mapped[3:0];
              FIELD_DAY:    day_d    = mapped[4:0];
              FIELD_HOUR:   hour_d   = mapped[4:0];
              FIELD_MINUTE: minute_d = mapped[5:0];
              FIELD_SECOND: second_d = mapped[5:0];
              default:      ;
            endcase
          end
        end
        CMD_CONFIRM: begin
          if (editing) begin
            edit_d = field_e'(edit_q + 3'd1);
            if (edit_q == FIELD_SECOND) centi_d = 7'd0;
          end
        end
        CMD_START: begin
          if (!running_q && edit_q == FIELD_DONE) running_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      year_q      <= YearReset;
      month_q     <= 4'd1;
      day_q       <= 5'd1;
      hour_q      <= 5'd0;
      minute_q    <= 6'd0;
      second_q    <= 6'd0;
      centi_q     <= 7'd0;
      running_q   <= 1'b0;
      edit_q      <= FIELD_YEAR;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      year_q      <= year_d;
      month_q     <= month_d;
      day_q       <= day_d;
      hour_q      <= hour_d;
      minute_q    <= minute_d;
      second_q    <= second_d;
      centi_q     <= centi_d;
      running_q   <= running_d;
      edit_q      <= edit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= cmd_e'(cmd_i);
      knob_q <= knob_i;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign year_out_o       = year_q;
  assign month_out_o      = month_q;
  assign day_out_o        = day_q;
  assign hour_out_o       = hour_q;
  assign minute_out_o     = minute_q;
  assign second_out_o     = second_q;
  assign centi_out_o      = centi_q;
  assign running_out_o    = running_q;
  assign edit_field_out_o = edit_q;

  // the clock only runs once every field has been confirmed
  a_run_after_setting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> edit_q == FIELD_DONE)
    else $error("clock running before all fields were set");

  // centiseconds, seconds, day and year hold unless a word is processed
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(centi_q) && $stable(second_q) && $stable(day_q) && $stable(year_q))
    else $error("calendar changed without a word");

  // running is only entered by a start press
  a_start_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(running_q) |-> $past(fire) && $past(cmd_q) == CMD_START)
    else $error("running set without start press");

  a_centi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    centi_q <= CentiLast)
    else $error("centiseconds out of range");

endmodule
